[rtl/core/stream_rate_jitter_monitor_macros.svh]
// Assertion macros shared by the stream rate and jitter monitor RTL.
`ifndef STREAM_RATE_JITTER_MONITOR_MACROS_SVH
`define STREAM_RATE_JITTER_MONITOR_MACROS_SVH

// Same-cycle implication, sampled on clk and held off during rst.
`define SRJM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("srjm assertion failed");

// Next-cycle implication, sampled on clk and held off during rst.
`define SRJM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("srjm assertion failed");

`endif

[rtl/core/srjm_pkg.sv]
// Types and constants shared by the stream rate and jitter monitor.
`default_nettype none
package srjm_pkg;

  localparam int unsigned CNT_W = 7;

  // Configuration register indexes.
  localparam logic [1:0] REG_MIN_GAP = 2'd0;
  localparam logic [1:0] REG_BURST   = 2'd1;
  localparam logic [1:0] REG_STALL   = 2'd2;

  localparam logic [15:0] MIN_GAP_RST = 16'd10;
  localparam logic [15:0] BURST_RST   = 16'd5;
  localparam logic [7:0]  STALL_RST   = 8'd2;

  // Rate scale: frames/s in Q16.16 is dframes * 1000 * 65536 / dt.
  localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;
  localparam logic [47:0] SAT48 = 48'hFFFF_FFFF_FFFF;

  // Operations of the shared serial unit.
  typedef enum logic [1:0] {
    ALU_DIV,
    ALU_MUL,
    ALU_SQRT
  } alu_op_t;

  typedef struct packed {
    logic             start;
    alu_op_t          op;
    logic [CNT_W-1:0] count;
    logic [63:0]      num;
    logic [47:0]      rem0;
    logic [47:0]      den;
  } alu_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] quo;
    logic [95:0] prod;
  } alu_rsp_t;

  // Sequencer states.
  typedef enum logic [4:0] {
    S_IDLE,
    S_DELTA,
    S_GATE,
    S_RATE,
    S_RATE_W,
    S_BITR,
    S_BITR_W,
    S_INTV,
    S_INTV_W,
    S_DELT1,
    S_MEAN,
    S_MEAN_W,
    S_DELT2,
    S_MUL,
    S_MUL_W,
    S_ACC,
    S_VAR,
    S_VAR_W,
    S_SQRT,
    S_SQRT_W,
    S_FIN
  } st_t;

endpackage
`default_nettype wire

[rtl/core/srjm_alu.sv]
// Shared bit-serial unit: restoring divide, shift-add multiply, integer square root.
`default_nettype none
module srjm_alu (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire srjm_pkg::alu_req_t req,
  output srjm_pkg::alu_rsp_t    rsp
);

  srjm_pkg::alu_op_t            op;
  logic [srjm_pkg::CNT_W-1:0]   cnt;
  logic [63:0]                  num;
  logic [47:0]                  rem;
  logic [47:0]                  den;
  logic [63:0]                  quo;
  logic [95:0]                  acc;
  logic [63:0]                  sbit;
  logic                         busy;
  logic                         done;

  logic [48:0] r2;
  logic [48:0] rsub;
  logic        dge;
  logic [95:0] macc;
  logic [64:0] st;
  logic        sge;

  // One step of each operation; only the selected one is kept.
  always_comb begin
    r2   = {rem, num[63]};
    dge  = r2 >= {1'b0, den};
    rsub = r2 - {1'b0, den};
    macc = {acc[94:0], 1'b0} + (num[63] ? {48'd0, den} : 96'd0);
    st   = {1'b0, quo} + {1'b0, sbit};
    sge  = {1'b0, num} >= st;
  end

  // Control: busy while steps remain, done pulses after the last one.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.count;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == srjm_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (req.start) begin
      op   <= req.op;
      num  <= req.num;
      rem  <= req.rem0;
      den  <= req.den;
      quo  <= '0;
      acc  <= '0;
      sbit <= 64'h4000_0000_0000_0000;
    end else if (busy) begin
      case (op)
        srjm_pkg::ALU_DIV: begin
          num <= {num[62:0], 1'b0};
          if (dge) begin
            rem <= rsub[47:0];
            quo <= {quo[62:0], 1'b1};
          end else begin
            rem <= r2[47:0];
            quo <= {quo[62:0], 1'b0};
          end
        end
        srjm_pkg::ALU_MUL: begin
          num <= {num[62:0], 1'b0};
          acc <= macc;
        end
        srjm_pkg::ALU_SQRT: begin
          sbit <= {2'b00, sbit[63:2]};
          if (sge) begin
            num <= num - st[63:0];
            quo <= {1'b0, quo[63:1]} + sbit;
          end else begin
            quo <= {1'b0, quo[63:1]};
          end
        end
        default: begin
          num <= num;
        end
      endcase
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo  = quo;
  assign rsp.prod = acc;

endmodule
`default_nettype wire

[rtl/core/stream_rate_jitter_monitor.sv]
// Top level of the stream rate and jitter monitor: event logic, sequencer, output register.
//
//   channel | direction | handshake             | payload
//   in      | sink      | in_valid / in_ready   | timestamp_ms frames_total bytes_total losses_total
//   out     | source    | out_valid / out_ready | rates, jitter, loss and stall events
//   cfg     | sink      | cfg_valid / cfg_ready | cfg_index cfg_data
//
// With no rates recomputed a snapshot goes from the gate to the output register; the
// longest path (rates, interval, mean, product, variance, square root) uses the shared
// bit-serial unit. Snapshots are taken only while idle. rst is synchronous and restores
// the sequencer, configuration, session state and out_valid to their defaults. A result
// that cannot enter the output register holds the sequencer in its last state. A new
// snapshot is taken while an earlier result still waits there. cfg_ready is always high.
`default_nettype none
`include "stream_rate_jitter_monitor_macros.svh"
module stream_rate_jitter_monitor (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [47:0] timestamp_ms,
  input  wire logic [47:0] frames_total,
  input  wire logic [47:0] bytes_total,
  input  wire logic signed [31:0] losses_total,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      frame_rate_q16,
  output logic [31:0]      kbit_rate,
  output logic [31:0]      jitter_ms_q16,
  output logic             first_drop,
  output logic             loss_burst,
  output logic [31:0]      burst_size,
  output logic             stall_start,
  output logic             stall_end,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  srjm_pkg::st_t      state;
  srjm_pkg::st_t      state_next;
  srjm_pkg::alu_req_t alu_req;
  srjm_pkg::alu_rsp_t alu_rsp;

  // Configuration.
  logic [15:0] min_gap_ms;
  logic [15:0] burst_threshold;
  logic [7:0]  stall_ticks;

  // Session state.
  logic        have_previous;
  logic [47:0] prev_time;
  logic [47:0] prev_frames;
  logic [47:0] prev_bytes;
  logic [31:0] base_loss;
  logic [31:0] interval_count;
  logic [47:0] interval_mean;
  logic [63:0] sum_sq_dev;
  logic [31:0] last_rate;
  logic [31:0] last_bitrate;
  logic [31:0] last_jitter;
  logic        seen_loss;
  logic        stalled;
  logic [7:0]  idle_ticks;

  // Working registers of one snapshot.
  logic [47:0] in_ts;
  logic [47:0] in_fr;
  logic [47:0] in_by;
  logic [31:0] in_lo;
  logic [47:0] dt;
  logic [47:0] dfr;
  logic [47:0] dby;
  logic        fwd;
  logic [57:0] k1000;
  logic [47:0] interval;
  logic [47:0] dmag1;
  logic        dneg;
  logic [47:0] dmag2;
  logic        ev_first;
  logic        ev_burst;
  logic [31:0] ev_size;
  logic        ev_sstart;
  logic        ev_send;

  logic        accept;
  logic        fin_load;
  logic        alu_wait;

  srjm_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // Event decisions against the previous baseline.
  logic [32:0] rise;
  logic [15:0] thr_eff;
  logic        ev_burst_c;
  logic        idle_c;
  logic [7:0]  idle_inc;
  always_comb begin
    rise       = {losses_total[31], losses_total} - {base_loss[31], base_loss};
    thr_eff    = (burst_threshold == 16'd0) ? 16'd1 : burst_threshold;
    ev_burst_c = $signed(rise) >= $signed({17'd0, thr_eff});
    idle_c     = frames_total <= prev_frames;
    idle_inc   = (idle_ticks == 8'hFF) ? idle_ticks : idle_ticks + 8'd1;
  end

  // Saturation checks and Welford differences.
  logic        rate_sat;
  logic        bitr_sat;
  logic        intv_sat;
  logic [48:0] d1;
  logic [48:0] d2;
  logic [31:0] cnt_inc;
  logic [64:0] sum65;
  always_comb begin
    rate_sat = {6'd0, k1000[57:16]} >= dt;
    bitr_sat = {29'd0, dby[47:29]} >= dt;
    intv_sat = {32'd0, dt[47:32]} >= dfr;
    d1       = {1'b0, interval} - {1'b0, interval_mean};
    d2       = {1'b0, interval} - {1'b0, interval_mean};
    cnt_inc  = (interval_count == srjm_pkg::SAT32) ? interval_count : interval_count + 32'd1;
    sum65    = {1'b0, sum_sq_dev} + {1'b0, alu_rsp.prod[63:0]};
  end

  assign accept   = in_valid && in_ready;
  assign fin_load = (state == srjm_pkg::S_FIN) && (!out_valid || out_ready);
  assign cfg_ready = 1'b1;

  // States that wait for the shared unit to finish.
  assign alu_wait = (state == srjm_pkg::S_RATE_W) || (state == srjm_pkg::S_BITR_W) ||
                    (state == srjm_pkg::S_INTV_W) || (state == srjm_pkg::S_MEAN_W) ||
                    (state == srjm_pkg::S_MUL_W) || (state == srjm_pkg::S_VAR_W) ||
                    (state == srjm_pkg::S_SQRT_W);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      srjm_pkg::S_IDLE:   if (in_valid) state_next = srjm_pkg::S_DELTA;
      srjm_pkg::S_DELTA:  state_next = srjm_pkg::S_GATE;
      srjm_pkg::S_GATE: begin
        if (fwd && (dt > {32'd0, min_gap_ms})) state_next = srjm_pkg::S_RATE;
        else state_next = srjm_pkg::S_FIN;
      end
      srjm_pkg::S_RATE:   state_next = rate_sat ? srjm_pkg::S_BITR : srjm_pkg::S_RATE_W;
      srjm_pkg::S_RATE_W: if (alu_rsp.done) state_next = srjm_pkg::S_BITR;
      srjm_pkg::S_BITR:   state_next = bitr_sat ? srjm_pkg::S_BITR_W : srjm_pkg::S_BITR_W;
      srjm_pkg::S_BITR_W: begin
        if (bitr_sat || alu_rsp.done) begin
          state_next = (dfr == 48'd0) ? srjm_pkg::S_FIN : srjm_pkg::S_INTV;
        end
      end
      srjm_pkg::S_INTV:   state_next = intv_sat ? srjm_pkg::S_DELT1 : srjm_pkg::S_INTV_W;
      srjm_pkg::S_INTV_W: if (alu_rsp.done) state_next = srjm_pkg::S_DELT1;
      srjm_pkg::S_DELT1:  state_next = srjm_pkg::S_MEAN;
      srjm_pkg::S_MEAN:   state_next = srjm_pkg::S_MEAN_W;
      srjm_pkg::S_MEAN_W: if (alu_rsp.done) state_next = srjm_pkg::S_DELT2;
      srjm_pkg::S_DELT2:  state_next = srjm_pkg::S_MUL;
      srjm_pkg::S_MUL:    state_next = srjm_pkg::S_MUL_W;
      srjm_pkg::S_MUL_W:  if (alu_rsp.done) state_next = srjm_pkg::S_ACC;
      srjm_pkg::S_ACC: begin
        state_next = (interval_count > 32'd1) ? srjm_pkg::S_VAR : srjm_pkg::S_FIN;
      end
      srjm_pkg::S_VAR:    state_next = srjm_pkg::S_VAR_W;
      srjm_pkg::S_VAR_W:  if (alu_rsp.done) state_next = srjm_pkg::S_SQRT;
      srjm_pkg::S_SQRT:   state_next = srjm_pkg::S_SQRT_W;
      srjm_pkg::S_SQRT_W: if (alu_rsp.done) state_next = srjm_pkg::S_FIN;
      srjm_pkg::S_FIN:    if (!out_valid || out_ready) state_next = srjm_pkg::S_IDLE;
      default:            state_next = srjm_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs: input ready and requests to the shared unit.
  always_comb begin
    in_ready      = (state == srjm_pkg::S_IDLE);
    alu_req.start = 1'b0;
    alu_req.op    = srjm_pkg::ALU_DIV;
    alu_req.count = '0;
    alu_req.num   = '0;
    alu_req.rem0  = '0;
    alu_req.den   = dt;
    case (state)
      srjm_pkg::S_RATE: begin
        alu_req.start = !rate_sat;
        alu_req.count = srjm_pkg::CNT_W'(32);
        alu_req.num   = {k1000[15:0], 48'd0};
        alu_req.rem0  = {6'd0, k1000[57:16]};
      end
      srjm_pkg::S_BITR: begin
        alu_req.start = !bitr_sat;
        alu_req.count = srjm_pkg::CNT_W'(32);
        alu_req.num   = {dby[28:0], 35'd0};
        alu_req.rem0  = {29'd0, dby[47:29]};
      end
      srjm_pkg::S_INTV: begin
        alu_req.start = !intv_sat;
        alu_req.count = srjm_pkg::CNT_W'(48);
        alu_req.num   = {dt[31:0], 32'd0};
        alu_req.rem0  = {32'd0, dt[47:32]};
        alu_req.den   = dfr;
      end
      srjm_pkg::S_MEAN: begin
        alu_req.start = 1'b1;
        alu_req.count = srjm_pkg::CNT_W'(48);
        alu_req.num   = {dmag1, 16'd0};
        alu_req.den   = {16'd0, interval_count};
      end
      srjm_pkg::S_MUL: begin
        alu_req.start = 1'b1;
        alu_req.op    = srjm_pkg::ALU_MUL;
        alu_req.count = srjm_pkg::CNT_W'(48);
        alu_req.num   = {dmag1, 16'd0};
        alu_req.den   = dmag2;
      end
      srjm_pkg::S_VAR: begin
        alu_req.start = 1'b1;
        alu_req.count = srjm_pkg::CNT_W'(64);
        alu_req.num   = sum_sq_dev;
        alu_req.den   = {16'd0, interval_count - 32'd1};
      end
      srjm_pkg::S_SQRT: begin
        alu_req.start = 1'b1;
        alu_req.op    = srjm_pkg::ALU_SQRT;
        alu_req.count = srjm_pkg::CNT_W'(32);
        alu_req.num   = alu_rsp.quo;
      end
      default: begin
        alu_req.start = 1'b0;
      end
    endcase
  end

  // State register, configuration and session state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= srjm_pkg::S_IDLE;
      min_gap_ms      <= srjm_pkg::MIN_GAP_RST;
      burst_threshold <= srjm_pkg::BURST_RST;
      stall_ticks     <= srjm_pkg::STALL_RST;
      have_previous   <= 1'b0;
      prev_time       <= '0;
      prev_frames     <= '0;
      prev_bytes      <= '0;
      base_loss       <= '0;
      interval_count  <= '0;
      interval_mean   <= '0;
      sum_sq_dev      <= '0;
      last_rate       <= '0;
      last_bitrate    <= '0;
      last_jitter     <= '0;
      seen_loss       <= 1'b0;
      stalled         <= 1'b0;
      idle_ticks      <= '0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;

      // Register writes.
      if (cfg_valid) begin
        case (cfg_index)
          srjm_pkg::REG_MIN_GAP: min_gap_ms      <= cfg_data;
          srjm_pkg::REG_BURST:   burst_threshold <= cfg_data;
          srjm_pkg::REG_STALL:   stall_ticks     <= cfg_data[7:0];
          default:               min_gap_ms      <= min_gap_ms;
        endcase
      end

      // Loss and stall tracking on each accepted snapshot.
      if (accept) begin
        if (!seen_loss && ($signed(losses_total) > 32'sd0)) seen_loss <= 1'b1;
        if (idle_c) begin
          idle_ticks <= idle_inc;
          if (!stalled && (idle_inc >= stall_ticks)) stalled <= 1'b1;
        end else begin
          idle_ticks <= '0;
          stalled    <= 1'b0;
        end
      end

      // Baseline moves to the new snapshot once the gap is judged.
      if (state == srjm_pkg::S_GATE) begin
        have_previous <= 1'b1;
        prev_time     <= in_ts;
        prev_frames   <= in_fr;
        prev_bytes    <= in_by;
        base_loss     <= in_lo;
      end

      // Rate results.
      if (state == srjm_pkg::S_RATE && rate_sat) last_rate <= srjm_pkg::SAT32;
      if (state == srjm_pkg::S_RATE_W && alu_rsp.done) last_rate <= alu_rsp.quo[31:0];
      if (state == srjm_pkg::S_BITR && bitr_sat) last_bitrate <= srjm_pkg::SAT32;
      if (state == srjm_pkg::S_BITR_W && alu_rsp.done) last_bitrate <= alu_rsp.quo[31:0];

      // Welford update.
      if (state == srjm_pkg::S_DELT1) interval_count <= cnt_inc;
      if (state == srjm_pkg::S_MEAN_W && alu_rsp.done) begin
        if (dneg) interval_mean <= interval_mean - alu_rsp.quo[47:0];
        else      interval_mean <= interval_mean + alu_rsp.quo[47:0];
      end
      if (state == srjm_pkg::S_ACC) begin
        if ((alu_rsp.prod[95:64] != 32'd0) || sum65[64]) sum_sq_dev <= '1;
        else sum_sq_dev <= sum65[63:0];
        if (interval_count <= 32'd1) last_jitter <= '0;
      end
      if (state == srjm_pkg::S_SQRT_W && alu_rsp.done) last_jitter <= alu_rsp.quo[31:0];

      // Output register handshake.
      if (fin_load)       out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Snapshot working registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      in_ts     <= timestamp_ms;
      in_fr     <= frames_total;
      in_by     <= bytes_total;
      in_lo     <= losses_total;
      ev_first  <= !seen_loss && ($signed(losses_total) > 32'sd0);
      ev_burst  <= ev_burst_c;
      ev_size   <= ev_burst_c ? rise[31:0] : 32'd0;
      ev_sstart <= idle_c && !stalled && (idle_inc >= stall_ticks);
      ev_send   <= !idle_c && stalled;
    end
    if (state == srjm_pkg::S_DELTA) begin
      dt  <= in_ts - prev_time;
      dfr <= in_fr - prev_frames;
      dby <= in_by - prev_bytes;
      fwd <= have_previous && (in_ts > prev_time) && (in_fr >= prev_frames)
             && (in_by >= prev_bytes);
    end
    // dframes * 1000 as 1024 - 16 - 8.
    if (state == srjm_pkg::S_GATE) begin
      k1000 <= {dfr, 10'd0} - {6'd0, dfr, 4'd0} - {7'd0, dfr, 3'd0};
    end
    if (state == srjm_pkg::S_INTV && intv_sat) interval <= srjm_pkg::SAT48;
    if (state == srjm_pkg::S_INTV_W && alu_rsp.done) interval <= alu_rsp.quo[47:0];
    if (state == srjm_pkg::S_DELT1) begin
      dneg  <= d1[48];
      dmag1 <= d1[48] ? 48'(-d1) : d1[47:0];
    end
    if (state == srjm_pkg::S_DELT2) begin
      dmag2 <= d2[48] ? 48'(-d2) : d2[47:0];
    end
    if (fin_load) begin
      frame_rate_q16 <= last_rate;
      kbit_rate      <= last_bitrate;
      jitter_ms_q16  <= last_jitter;
      first_drop     <= ev_first;
      loss_burst     <= ev_burst;
      burst_size     <= ev_size;
      stall_start    <= ev_sstart;
      stall_end      <= ev_send;
    end
  end

  // Checks.
  `SRJM_ASSERT_NOW(a_start_idle, alu_req.start, !alu_rsp.busy)
  `SRJM_ASSERT_NOW(a_done_waits, alu_rsp.done, alu_wait)
  `SRJM_ASSERT_NOW(a_stall_excl, out_valid, !(stall_start && stall_end))
  `SRJM_ASSERT_NOW(a_burst_size, out_valid, loss_burst == (burst_size != 32'd0))

endmodule
`default_nettype wire
